/* sv/cbrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbrs_pkg;

    localparam int ROWS      = 64;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int ROW_W     = 8;
    localparam int COL_W     = 8;
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    localparam logic [ROW_W-1:0] EMPTY_TOP    = 8'hff;
    localparam logic [ROW_W-1:0] EMPTY_BOTTOM = 8'h00;
    localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(ROWS - 1);

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] top_row;
        logic [ROW_W-1:0] bottom_row;
        logic             first_column;
    } col_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] span_row;
        logic [COL_W-1:0] span_start;
        logic [COL_W-1:0] span_end;
        logic             last_span;
    } span_item_t;

    // one column's work: old extent (t1, b1) against new extent (t2, b2)
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] t1;
        logic [ROW_W-1:0] b1;
        logic [ROW_W-1:0] t2;
        logic [ROW_W-1:0] b2;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

/* sv/column_bounds_to_row_spans.sv */
// the back end works on one item at a time, closing and then opening its rows one at a time
// through the row store port.
// a two-deep command queue lets the input take new items while the back end works.
// reset: previous extent empty (top 255, bottom 0), queues empty, row store unset.
`timescale 1ns / 1ps
`default_nettype none

module column_bounds_to_row_spans (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 col_valid,
    output logic                      col_stall,
    input  wire cbrs_pkg::col_item_t  col_item,
    output logic                      span_valid,
    input  wire logic                 span_stall,
    output cbrs_pkg::span_item_t      span_item
);

    cbrs_pkg::queue_status_t q_status;
    cbrs_pkg::cmd_t          push_cmd;
    cbrs_pkg::cmd_t          head_cmd;
    logic                    push;
    logic                    pop;

    cbrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_valid (col_valid),
        .col_stall (col_stall),
        .col_item  (col_item),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    cbrs_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    cbrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .span_item  (span_item)
    );

endmodule

`default_nettype wire

/* sv/cbrs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/cbrs_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbrs_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   col_valid,
    output logic                        col_stall,
    input  wire cbrs_pkg::col_item_t    col_item,
    input  wire cbrs_pkg::queue_status_t q_status,
    output logic                        push,
    output cbrs_pkg::cmd_t              push_cmd
);

    logic [cbrs_pkg::ROW_W-1:0] prev_top_reg, prev_top_next;
    logic [cbrs_pkg::ROW_W-1:0] prev_bottom_reg, prev_bottom_next;
    logic [cbrs_pkg::ROW_W-1:0] b2_sat;

    assign col_stall = q_status.full;
    assign push      = col_valid && !q_status.full;

    // rows past the store are never opened or closed
    assign b2_sat = (col_item.bottom_row > cbrs_pkg::LAST_ROW) ? cbrs_pkg::LAST_ROW
                                                               : col_item.bottom_row;

    always_comb
    begin
        push_cmd.col = col_item.column;
        push_cmd.t2  = col_item.top_row;
        push_cmd.b2  = b2_sat;
        if (col_item.first_column)
        begin
            push_cmd.t1 = cbrs_pkg::EMPTY_TOP;
            push_cmd.b1 = cbrs_pkg::EMPTY_BOTTOM;
        end
        else
        begin
            push_cmd.t1 = prev_top_reg;
            push_cmd.b1 = prev_bottom_reg;
        end
        prev_top_next    = push ? col_item.top_row : prev_top_reg;
        prev_bottom_next = push ? b2_sat : prev_bottom_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_top_reg    <= cbrs_pkg::EMPTY_TOP;
            prev_bottom_reg <= cbrs_pkg::EMPTY_BOTTOM;
        end
        else
        begin
            prev_top_reg    <= prev_top_next;
            prev_bottom_reg <= prev_bottom_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cbrs_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbrs_cmd_fifo (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire cbrs_pkg::cmd_t          push_cmd,
    input  wire logic                    pop,
    output cbrs_pkg::cmd_t               head_cmd,
    output cbrs_pkg::queue_status_t      status
);

    localparam int PW = $clog2(cbrs_pkg::CMD_DEPTH);
    localparam int CW = $clog2(cbrs_pkg::CMD_DEPTH + 1);

    cbrs_pkg::cmd_t mem_reg [cbrs_pkg::CMD_DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == CW'(cbrs_pkg::CMD_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(cbrs_pkg::CMD_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(cbrs_pkg::CMD_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("command queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(cbrs_pkg::CMD_DEPTH))
        else $error("command queue count out of range");

endmodule

`default_nettype wire

/* sv/cbrs_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbrs_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cbrs_pkg::queue_status_t q_status,
    input  wire cbrs_pkg::cmd_t          head_cmd,
    output logic                         pop,
    output logic                         span_valid,
    input  wire logic                    span_stall,
    output cbrs_pkg::span_item_t         span_item
);

    localparam int OPW = $clog2(cbrs_pkg::OUT_DEPTH);
    localparam int OCW = $clog2(cbrs_pkg::OUT_DEPTH + 1);
    localparam int AW  = cbrs_pkg::ROW_AW;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_CLOSE_TOP = 5'b00010,
        S_CLOSE_BOT = 5'b00100,
        S_OPEN_TOP  = 5'b01000,
        S_OPEN_BOT  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    cbrs_pkg::cmd_t               cur_reg, cur_next;
    logic                         pend_reg, pend_next;
    logic [cbrs_pkg::ROW_W-1:0]   prow_reg, prow_next;
    logic                         plast_reg, plast_next;

    cbrs_pkg::span_item_t         out_mem_reg [cbrs_pkg::OUT_DEPTH];
    logic [OPW-1:0]               owptr_reg, owptr_next;
    logic [OPW-1:0]               orptr_reg, orptr_next;
    logic [OCW-1:0]               ocount_reg, ocount_next;

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [cbrs_pkg::COL_W-1:0]   ram_rdata;

    logic                         out_pop;
    logic [OCW:0]                 committed;
    logic                         credit_ok;
    logic                         close_top, close_bot, open_top, open_bot;
    logic [cbrs_pkg::ROW_W-1:0]   t1_inc, b1_dec;
    cbrs_pkg::span_item_t         arrive_item;

    cbrs_ram #(
        .WIDTH (cbrs_pkg::COL_W),
        .DEPTH (cbrs_pkg::ROWS)
    ) u_row_open (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg.col),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign close_top = (cur_reg.t1 < cur_reg.t2) && (cur_reg.t1 <= cur_reg.b1);
    assign close_bot = (cur_reg.b1 > cur_reg.b2) && (cur_reg.b1 >= cur_reg.t1);
    assign open_top  = (cur_reg.t2 < cur_reg.t1) && (cur_reg.t2 <= cur_reg.b2);
    assign open_bot  = (cur_reg.b2 > cur_reg.b1) && (cur_reg.b2 >= cur_reg.t2);
    assign t1_inc    = cur_reg.t1 + 1'b1;
    assign b1_dec    = cur_reg.b1 - 1'b1;

    assign out_pop    = span_valid && !span_stall;
    // slots already taken or promised to a read in flight
    assign committed  = (OCW+1)'(ocount_reg) + (OCW+1)'(pend_reg) - (OCW+1)'(out_pop);
    assign credit_ok  = committed < (OCW+1)'(cbrs_pkg::OUT_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = cur_reg.t2[AW-1:0];
        ram_raddr  = cur_reg.t1[AW-1:0];
        pend_next  = 1'b0;
        prow_next  = prow_reg;
        plast_next = plast_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head_cmd;
                    state_next = S_CLOSE_TOP;
                end
            end
            S_CLOSE_TOP:
            begin
                if (!close_top)
                begin
                    state_next = S_CLOSE_BOT;
                end
                else if (credit_ok)
                begin
                    ram_re      = 1'b1;
                    pend_next   = 1'b1;
                    prow_next   = cur_reg.t1;
                    // last if neither close loop has a row left after this one
                    plast_next  = !(((t1_inc < cur_reg.t2) && (t1_inc <= cur_reg.b1))
                                  || ((cur_reg.b1 > cur_reg.b2) && (cur_reg.b1 >= t1_inc)));
                    cur_next.t1 = t1_inc;
                end
            end
            S_CLOSE_BOT:
            begin
                ram_raddr = cur_reg.b1[AW-1:0];
                if (!close_bot)
                begin
                    state_next = S_OPEN_TOP;
                end
                else if (credit_ok)
                begin
                    ram_re      = 1'b1;
                    pend_next   = 1'b1;
                    prow_next   = cur_reg.b1;
                    plast_next  = !((b1_dec > cur_reg.b2) && (b1_dec >= cur_reg.t1));
                    cur_next.b1 = b1_dec;
                end
            end
            S_OPEN_TOP:
            begin
                if (!open_top)
                begin
                    state_next = S_OPEN_BOT;
                end
                else
                begin
                    ram_we      = 1'b1;
                    cur_next.t2 = cur_reg.t2 + 1'b1;
                end
            end
            S_OPEN_BOT:
            begin
                ram_waddr = cur_reg.b2[AW-1:0];
                if (!open_bot)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_we      = 1'b1;
                    cur_next.b2 = cur_reg.b2 - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign arrive_item.span_row   = prow_reg;
    assign arrive_item.span_start = ram_rdata;
    assign arrive_item.span_end   = cur_reg.col - 1'b1;
    assign arrive_item.last_span  = plast_reg;

    assign span_valid = (ocount_reg != '0);
    assign span_item  = out_mem_reg[orptr_reg];

    always_comb
    begin
        owptr_next  = owptr_reg;
        orptr_next  = orptr_reg;
        ocount_next = ocount_reg;
        if (pend_reg)
        begin
            owptr_next = (owptr_reg == OPW'(cbrs_pkg::OUT_DEPTH - 1)) ? '0 : owptr_reg + 1'b1;
        end
        if (out_pop)
        begin
            orptr_next = (orptr_reg == OPW'(cbrs_pkg::OUT_DEPTH - 1)) ? '0 : orptr_reg + 1'b1;
        end
        unique case ({pend_reg, out_pop})
            2'b10:   ocount_next = ocount_reg + 1'b1;
            2'b01:   ocount_next = ocount_reg - 1'b1;
            default: ocount_next = ocount_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        prow_reg  <= prow_next;
        plast_reg <= plast_next;
        if (pend_reg)
        begin
            out_mem_reg[owptr_reg] <= arrive_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            owptr_reg  <= '0;
            orptr_reg  <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            owptr_reg  <= owptr_next;
            orptr_reg  <= orptr_next;
            ocount_reg <= ocount_next;
        end
    end

    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        ((OCW+1)'(ocount_reg) + (OCW+1)'(pend_reg)) <= (OCW+1)'(cbrs_pkg::OUT_DEPTH))
        else $error("span buffer overcommitted");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("row store read and written in one cycle");

    a_read_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_CLOSE_TOP || state_reg == S_CLOSE_BOT))
        else $error("row store data returned outside a close phase");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_CLOSE_TOP))
        else $error("command taken without starting the close phase");

endmodule

`default_nettype wire
